/* sv/cfd_pkg.sv */
// Shared types and constants for the COBS frame decoder.
package cfd_pkg;

	localparam int BYTE_W        = 8;
	localparam int LEN_W         = 13;
	localparam int LEN_CAP       = 4096;
	localparam int MAX_FRAME_DEF = 4096;
	localparam int RES_DEPTH     = 4;
	localparam int PTR_W         = $clog2(RES_DEPTH);
	localparam int CNT_W         = $clog2(RES_DEPTH + 1);
	localparam int MAX_RES       = 3;
	localparam int OUT_TDATA_W   = 24;

	localparam logic [BYTE_W-1:0] CODE_MAX = 8'hFF;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  byte_val;
		logic [LEN_W-1:0]   len;
		logic               run_last;
	} res_t;

endpackage

/* sv/cobs_frame_decoder.sv */
// COBS frame decoder top level.
//
// Usage: encoded bytes enter on the s_ channel, one per item, with s_tlast
// on the final byte of a frame. Decoded items leave on the m_ channel:
// m_tuser low is a data byte, m_tuser high is the frame end item carrying
// the decoded length (written count minus one, all ones when nothing was
// written). m_tlast marks the last result item caused by one input item.
// The final written byte of each frame is dropped and never shown.
// Each result enters the result queue when its input item is accepted.
// Throughput: one input item per cycle while each item causes at most one
// result and the receiver takes every item; the results go through a
// four-entry result queue that drains one item per cycle while m_tready is
// high, and s_tready is high while at least three entries are free, so
// after an item causing two or three results s_tready stays low until the
// queue is back to one entry. Reset clears the block state and empties the
// queue; the next byte is taken as a code byte. When the receiver stalls,
// the queue keeps its items and s_tready falls; nothing is lost or repeated.
module cobs_frame_decoder
	import cfd_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] enc_byte
	input  logic                   s_tlast,   // frame_last
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [20:8] decoded_len, rest 0
	output logic                   m_tuser,   // item_kind
	output logic                   m_tlast    // run_last
);

	localparam int CAP = (MAX_FRAME < LEN_CAP) ? MAX_FRAME : LEN_CAP;
	localparam logic [LEN_W:0] CAP_V = (LEN_W + 1)'(CAP);

	logic [BYTE_W-1:0] bytes_left_q;
	logic              short_block_q;
	logic              held_valid_q;
	logic [BYTE_W-1:0] held_value_q;
	logic [LEN_W-1:0]  written_q;

	res_t              mem [RES_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              accept, pop, data_br;
	logic [BYTE_W-1:0] nbl;
	logic              nsb, a_en, z_en;
	logic [BYTE_W-1:0] a_v;
	logic              e1, e2, e3;
	logic [1:0]        nwr, npush;
	logic [LEN_W:0]    wsum;
	logic [LEN_W-1:0]  wnew, len_v;
	logic [PTR_W-1:0]  off2, off3;
	res_t              r1, r2, r3;

	assign s_tready = cnt_q <= CNT_W'(RES_DEPTH - MAX_RES);
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = cnt_q != '0;
	assign pop      = m_tvalid & m_tready;

	always_comb begin
		data_br = bytes_left_q != '0;
		if (data_br) begin
			nbl  = bytes_left_q - 1'b1;
			nsb  = short_block_q;
			a_en = 1'b1;
			a_v  = s_tdata;
			z_en = (nbl == '0) && short_block_q;
		end else begin
			nbl  = (s_tdata == '0) ? '0 : s_tdata - 1'b1;
			nsb  = s_tdata != CODE_MAX;
			a_en = 1'b0;
			a_v  = '0;
			z_en = s_tdata <= BYTE_W'(1);
		end
		if (s_tlast && nbl != '0 && nsb) begin
			z_en = 1'b1;
		end

		e1 = held_valid_q && (a_en || z_en);
		e2 = a_en && z_en;
		e3 = s_tlast;

		nwr  = {1'b0, a_en} + {1'b0, z_en};
		wsum = {1'b0, written_q} + (LEN_W + 1)'(nwr);
		wnew = (wsum > CAP_V) ? CAP_V[LEN_W-1:0] : wsum[LEN_W-1:0];
		len_v = (wnew == '0) ? '1 : wnew - 1'b1;

		npush = {1'b0, e1} + {1'b0, e2} + {1'b0, e3};
		off2  = PTR_W'(e1);
		off3  = PTR_W'({1'b0, e1} + {1'b0, e2});

		r1 = '{kind: KIND_DATA, byte_val: held_value_q, len: '0, run_last: !e2 && !e3};
		r2 = '{kind: KIND_DATA, byte_val: a_v, len: '0, run_last: !e3};
		r3 = '{kind: KIND_END, byte_val: '0, len: len_v, run_last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			short_block_q <= 1'b0;
			held_valid_q  <= 1'b0;
			written_q     <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				bytes_left_q  <= '0;
				short_block_q <= 1'b0;
				held_valid_q  <= 1'b0;
				written_q     <= '0;
			end else begin
				bytes_left_q  <= nbl;
				short_block_q <= nsb;
				written_q     <= wnew;
				if (a_en || z_en) begin
					held_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (z_en) begin
				held_value_q <= '0;
			end else if (a_en) begin
				held_value_q <= a_v;
			end
			if (e1) begin
				mem[wr_q] <= r1;
			end
			if (e2) begin
				mem[wr_q + off2] <= r2;
			end
			if (e3) begin
				mem[wr_q + off3] <= r3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + PTR_W'(npush);
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (accept ? CNT_W'(npush) : '0) - CNT_W'(pop);
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tdata[BYTE_W-1:0] = mem[rd_q].byte_val;
		m_tdata[BYTE_W +: LEN_W] = mem[rd_q].len;
		m_tuser = mem[rd_q].kind;
		m_tlast = mem[rd_q].run_last;
	end

endmodule

/* sv/cfd_checker.sv */
// Port-level checks for the COBS frame decoder, bound to the top level.
module cfd_checker
	import cfd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_END |-> m_tlast)
		else $error("frame end item without tlast");

	a_data_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DATA |-> m_tdata[BYTE_W +: LEN_W] == '0)
		else $error("data item carries a length");

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_END |-> m_tdata[BYTE_W-1:0] == '0)
		else $error("frame end item carries a byte");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled item changed");

endmodule

bind cobs_frame_decoder cfd_checker u_cfd_checker (.*);

/* tb/testbench.sv */
// Testbench for cobs_frame_decoder: random COBS frames checked against a behavioral decoder.
`timescale 1ns / 100ps

module testbench;
	import cfd_pkg::*;

	localparam int CAP = (MAX_FRAME_DEF < LEN_CAP) ? MAX_FRAME_DEF : LEN_CAP;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_ITEMS = 40;
	localparam logic [8:0] LAST = 9'h100;

	typedef struct {
		logic [BYTE_W-1:0] enc;
		logic              last;
	} enc_item_t;

	typedef enum int {
		MODE_CLEAN,
		MODE_CUT,
		MODE_SPOIL,
		MODE_NOISE
	} frame_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [BYTE_W-1:0]      s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	enc_item_t enc_q[$];
	res_t      decoded_q[$];
	res_t      step_q[$];

	logic [BYTE_W-1:0] blk_left = '0;
	logic              blk_short = 1'b0;
	logic              held_ok = 1'b0;
	logic [BYTE_W-1:0] held_byte = '0;
	logic [LEN_W-1:0]  wr_count = '0;

	bit in_accepted = 1'b0;
	bit s_idle_en = 1'b1;
	bit m_idle_en = 1'b1;
	int s_gap = 0;
	int m_gap = 0;
	int stall_cycles = 0;
	int errors = 0;
	int gen_count = 0;

	cobs_frame_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic store_byte(input logic [BYTE_W-1:0] v);
		res_t r;
		if (held_ok) begin
			r = '{KIND_DATA, held_byte, '0, 1'b0};
			step_q = {step_q, r};
		end
		held_byte = v;
		held_ok = 1'b1;
		if (wr_count < CAP)
			wr_count++;
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [BYTE_W-1:0] code;
		res_t r;
		step_q = {};
		if (blk_left == 0) begin
			code = (b == 0) ? 8'd1 : b;
			blk_left = code - 8'd1;
			blk_short = (code < CODE_MAX);
			if (blk_left == 0 && blk_short)
				store_byte(8'h00);
		end else begin
			store_byte(b);
			blk_left--;
			if (blk_left == 0 && blk_short)
				store_byte(8'h00);
		end
		if (last) begin
			if (blk_left != 0 && blk_short)
				store_byte(8'h00);
			r.kind = KIND_END;
			r.byte_val = '0;
			r.len = (wr_count == 0) ? '1 : wr_count - 1'b1;
			r.run_last = 1'b0;
			step_q = {step_q, r};
			blk_left = '0;
			blk_short = 1'b0;
			held_ok = 1'b0;
			held_byte = '0;
			wr_count = '0;
		end
		if (step_q.size() > 0) begin
			r = step_q.pop_back();
			r.run_last = 1'b1;
			step_q = {step_q, r};
		end
		foreach (step_q[i])
			decoded_q = {decoded_q, step_q[i]};
	endtask

	task automatic add_raw(input logic [8:0] v);
		enc_item_t it;
		it.enc = v[7:0];
		it.last = v[8];
		enc_q = {enc_q, it};
	endtask

	task automatic add_frame(input int n_bytes, input int zero_odds, input frame_mode_t mode);
		logic [BYTE_W-1:0] body[$];
		logic [BYTE_W-1:0] run[$];
		logic [BYTE_W-1:0] v;
		enc_item_t it;
		for (int i = 0; i < n_bytes; i++) begin
			v = ($urandom_range(0, zero_odds - 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
			if (v == 0) begin
				body = {body, 8'(run.size() + 1)};
				body = {body, run};
				run = {};
			end else begin
				run = {run, v};
				if (run.size() == 254) begin
					body = {body, CODE_MAX};
					body = {body, run};
					run = {};
				end
			end
		end
		body = {body, 8'(run.size() + 1)};
		body = {body, run};
		case (mode)
			MODE_CUT: begin
				body = body[0:$urandom_range(0, body.size() - 1)];
			end
			MODE_SPOIL: begin
				body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
			end
			MODE_NOISE: begin
				body = {};
				repeat ($urandom_range(1, 8))
					body = {body, 8'($urandom)};
			end
			default: begin
			end
		endcase
		foreach (body[i]) begin
			it.enc = body[i];
			it.last = (i == body.size() - 1);
			enc_q = {enc_q, it};
		end
		gen_count += body.size();
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (in_accepted)
				void'(enc_q.pop_front());
			if ($urandom_range(0, 63) == 0)
				s_idle_en = !s_idle_en;
			if ($urandom_range(0, 63) == 0)
				m_idle_en = !m_idle_en;
			if (!s_tvalid || in_accepted) begin
				if (enc_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (s_gap != 0) begin
					s_gap--;
					s_tvalid <= 1'b0;
				end else if (enc_q.size() > CALM_ITEMS && s_idle_en
						&& $urandom_range(0, 3) == 0) begin
					s_gap = $urandom_range(0, 4);
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= enc_q[0].enc;
					s_tlast <= enc_q[0].last;
				end
			end
			if (m_gap != 0) begin
				m_gap--;
				m_tready <= 1'b0;
			end else if (enc_q.size() > CALM_ITEMS && m_idle_en
					&& $urandom_range(0, 3) == 0) begin
				m_gap = $urandom_range(0, 4);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		logic [OUT_TDATA_W-1:0] want_data;
		if (arst_n) begin
			in_accepted = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected item tuser=%0b tdata=%06h tlast=%0b",
						$time, m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					want_data = '0;
					want_data[BYTE_W-1:0] = want.byte_val;
					want_data[BYTE_W+LEN_W-1:BYTE_W] = want.len;
					if (m_tuser !== want.kind || m_tdata !== want_data
							|| m_tlast !== want.run_last) begin
						$display("%0t: mismatch expected %0b %02h %0d %0b, actual %0b %02h %0d %0b",
							$time, want.kind, want.byte_val, $signed(want.len),
							want.run_last, m_tuser, m_tdata[BYTE_W-1:0],
							$signed(m_tdata[BYTE_W+LEN_W-1:BYTE_W]), m_tlast);
						errors++;
					end
				end
			end
			if (in_accepted)
				decode_byte(s_tdata, s_tlast);
			if (in_accepted || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("cobs_frame_decoder test failed");
					$finish;
				end
			end
		end
	end

	initial begin
		frame_mode_t mode;
		int pick;
		add_raw(LAST | 9'h00);
		add_raw(LAST | 9'hFF);
		add_raw(LAST | 9'h02);
		add_raw(9'h01);
		add_raw(9'h01);
		add_raw(LAST | 9'h01);
		add_raw(9'h03);
		add_raw(9'h00);
		add_raw(9'hFF);
		add_raw(9'h02);
		add_raw(LAST | 9'hAB);
		add_raw(9'h05);
		add_raw(LAST | 9'h12);
		add_raw(9'h01);
		add_raw(9'h02);
		add_raw(LAST | 9'h80);
		add_raw(9'hFE);
		add_raw(9'h7F);
		add_raw(LAST | 9'h01);
		while (gen_count < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			mode = (pick < 14) ? MODE_CLEAN : (pick < 16) ? MODE_CUT :
				(pick < 18) ? MODE_SPOIL : MODE_NOISE;
			if ($urandom_range(0, 19) == 0)
				add_frame($urandom_range(250, 300), 400, mode);
			else
				add_frame($urandom_range(0, 24), 4, mode);
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (enc_q.size() != 0 || decoded_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0 && decoded_q.size() == 0)
			$display("cobs_frame_decoder test passed");
		else
			$display("cobs_frame_decoder test failed");
		$finish;
	end

endmodule

/* files.f */
sv/cfd_pkg.sv
sv/cobs_frame_decoder.sv
sv/cfd_checker.sv
tb/testbench.sv
